[design/ggd_pkg.sv]
// Shared types and constants for the grid disk dilation block.
package ggd_pkg;

   // Field widths of the item and result beats
   localparam int COORD_BITS     = 8;
   localparam int VALUE_BITS     = 8;
   localparam int RADIUS_BITS    = 4;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 8;

   // Command codes
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_READ  = 1'b1;

   // Result status codes
   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_RANGE = 1'b1;

   // Register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GRID_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GRID_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RADIUS      = 2'd2;

   // Register reset values
   localparam logic [COORD_BITS-1:0]  GRID_WIDTH_RESET  = 8'd128;
   localparam logic [COORD_BITS-1:0]  GRID_HEIGHT_RESET = 8'd128;
   localparam logic [RADIUS_BITS-1:0] RADIUS_RESET      = 4'd0;

   // Largest radius the radius register can express
   localparam int RADIUS_FIELD_MAX = (1 << RADIUS_BITS) - 1;

   typedef struct packed {
      logic                  cmd;
      logic [COORD_BITS-1:0] col;
      logic [COORD_BITS-1:0] row;
      logic [VALUE_BITS-1:0] value;
   } req_type;

   typedef struct packed {
      logic [VALUE_BITS-1:0] cell_value;
      logic                  status;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CENTER,
      ST_SCAN,
      ST_DRAIN,
      ST_DONE
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic clr_step;
      logic load;
      logic center;
      logic scan_step;
      logic finish;
   } ctrl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic clr_last;
      logic quick;
      logic scan_last;
   } ctrl_status_type;

endpackage

[design/grid_disk_dilation.sv]
// Top level of the grid disk dilation block: controller plus datapath.
//
//   channel  direction  handshake         payload
//   req      in         req_valid/stall   req_data  (cmd, col, row, value)
//   rsp      out        rsp_valid/stall   rsp_data  (cell_value, status)
//   csr      in         csr_valid/ready   csr_index, csr_wdata
//
// A write or an out-of-range read is answered from the output register in the cycle after its accept.
// An in-range read walks the center, scan, drain and done states; with r the clipped radius,
// one grid memory read port visits the center and then every disk offset up to r, one per cycle.
// After reset a clearing pass writes zero to all MAX_WIDTH*MAX_HEIGHT cells,
// one per cycle; req_stall stays high until it ends. Settings writes are always taken.
// A stalled result holds in the output register; the next beat waits for it.
module grid_disk_dilation #(
   parameter int MAX_WIDTH  = 128,
   parameter int MAX_HEIGHT = 128,
   parameter int MAX_RADIUS = 8,
   parameter int CELL_BITS  = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  ggd_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output ggd_pkg::rsp_type                   rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [ggd_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [ggd_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import ggd_pkg::*;

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   // Settings port never backs up
   assign csr_ready = 1'b1;

   ggd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   ggd_dpath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .MAX_RADIUS (MAX_RADIUS),
      .CELL_BITS  (CELL_BITS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

[design/ggd_ctrl.sv]
// Controller state machine: clearing pass, item accept, neighbor scan, result handoff.
module ggd_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  ggd_pkg::ctrl_status_type status,
   output ggd_pkg::ctrl_cmd_type    cmd
);
   import ggd_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      out_free;
   logic      accept;

   // Output register can take a beat when empty or drained this cycle
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign accept   = (state_ff == ST_IDLE) && out_free && req_valid;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (status.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept && !status.quick) begin
               state_in = ST_CENTER;
            end
         end
         ST_CENTER: begin
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (status.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Commands and handshake
   always_comb begin
      cmd           = '0;
      req_stall     = 1'b1;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
         end
         ST_IDLE: begin
            req_stall = !out_free;
            cmd.load  = accept;
         end
         ST_CENTER: begin
            cmd.center = 1'b1;
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
         end
         ST_DRAIN: begin
            cmd = '0;
         end
         ST_DONE: begin
            cmd.finish = out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
      rsp_valid_in = (cmd.load && status.quick) || cmd.finish || (rsp_valid_ff && rsp_stall);
   end

   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[design/ggd_dpath.sv]
// Datapath: settings registers, grid memory, disk scan counters and result register.
module ggd_dpath #(
   parameter int MAX_WIDTH  = 128,
   parameter int MAX_HEIGHT = 128,
   parameter int MAX_RADIUS = 8,
   parameter int CELL_BITS  = 8
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  ggd_pkg::req_type                       req_data,
   output ggd_pkg::rsp_type                       rsp_data,
   input  logic                                   csr_write,
   input  logic [ggd_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [ggd_pkg::CSR_DATA_BITS-1:0]      csr_wdata,
   input  ggd_pkg::ctrl_cmd_type                  cmd,
   output ggd_pkg::ctrl_status_type               status
);
   import ggd_pkg::*;

   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int RLIM  = (MAX_RADIUS < RADIUS_FIELD_MAX) ? MAX_RADIUS : RADIUS_FIELD_MAX;
   localparam int RW    = (RLIM > 1) ? $clog2(RLIM + 1) : 1;
   localparam int OW    = RW + 1;
   localparam int SW    = 2 * OW + 1;
   localparam int CW    = ((COORD_BITS > RW) ? COORD_BITS : RW) + 2;
   localparam logic [AW-1:0] ROW_STRIDE = AW'(MAX_WIDTH);
   localparam logic [AW-1:0] LAST_ADDR  = AW'(DEPTH - 1);

   // Settings registers
   logic [COORD_BITS-1:0]  width_ff;
   logic [COORD_BITS-1:0]  height_ff;
   logic [RADIUS_BITS-1:0] radius_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= GRID_WIDTH_RESET;
         height_ff <= GRID_HEIGHT_RESET;
         radius_ff <= RADIUS_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_GRID_WIDTH:  width_ff  <= csr_wdata;
            CSR_GRID_HEIGHT: height_ff <= csr_wdata;
            CSR_RADIUS:      radius_ff <= RADIUS_BITS'(csr_wdata);
            default: begin
            end
         endcase
      end
   end

   // Clip the usable area and the radius
   logic [COORD_BITS-1:0] eff_w;
   logic [COORD_BITS-1:0] eff_h;
   logic [RW-1:0]         eff_r;

   assign eff_w = (int'(width_ff) < MAX_WIDTH)   ? width_ff  : COORD_BITS'(MAX_WIDTH);
   assign eff_h = (int'(height_ff) < MAX_HEIGHT) ? height_ff : COORD_BITS'(MAX_HEIGHT);
   assign eff_r = (int'(radius_ff) > RLIM)       ? RW'(RLIM) : RW'(radius_ff);

   // Decode the incoming beat
   logic          req_inside;
   logic [AW-1:0] req_addr;

   assign req_inside = (req_data.col < eff_w) && (req_data.row < eff_h);
   assign req_addr   = AW'(AW'(req_data.row) * ROW_STRIDE + AW'(req_data.col));
   assign status.quick = (req_data.cmd == CMD_WRITE) || !req_inside;

   // Item registers
   logic [COORD_BITS-1:0] col_ff;
   logic [COORD_BITS-1:0] row_ff;
   logic [RW-1:0]         r_ff;
   logic [SW-1:0]         rr_ff;
   logic [AW-1:0]         center_addr_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         col_ff         <= req_data.col;
         row_ff         <= req_data.row;
         r_ff           <= eff_r;
         rr_ff          <= SW'(SW'(eff_r) * SW'(eff_r));
         center_addr_ff <= req_addr;
      end
   end

   // Disk offset counters, row-major from (-r,-r) to (r,r)
   logic signed [OW-1:0] dx_ff;
   logic signed [OW-1:0] dy_ff;
   logic signed [OW-1:0] r_s;

   assign r_s = $signed({1'b0, r_ff});
   assign status.scan_last = (dx_ff == r_s) && (dy_ff == r_s);

   always_ff @(posedge clock) begin
      if (cmd.center) begin
         dx_ff <= -r_s;
         dy_ff <= -r_s;
      end else if (cmd.scan_step) begin
         if (dx_ff == r_s) begin
            dx_ff <= -r_s;
            dy_ff <= dy_ff + OW'(1);
         end else begin
            dx_ff <= dx_ff + OW'(1);
         end
      end
   end

   // Neighbor coordinate, range and disk test
   logic signed [CW-1:0]   x_s;
   logic signed [CW-1:0]   y_s;
   logic signed [2*OW-1:0] dx_sq;
   logic signed [2*OW-1:0] dy_sq;
   logic [SW-1:0]          offset_sq;
   logic                   probe_ok;
   logic [AW-1:0]          probe_addr;

   assign x_s   = $signed({{(CW-COORD_BITS){1'b0}}, col_ff}) + {{(CW-OW){dx_ff[OW-1]}}, dx_ff};
   assign y_s   = $signed({{(CW-COORD_BITS){1'b0}}, row_ff}) + {{(CW-OW){dy_ff[OW-1]}}, dy_ff};
   assign dx_sq = dx_ff * dx_ff;
   assign dy_sq = dy_ff * dy_ff;
   assign offset_sq = {1'b0, $unsigned(dx_sq)} + {1'b0, $unsigned(dy_sq)};

   assign probe_ok = !x_s[CW-1] && !y_s[CW-1]
                     && (x_s[CW-2:0] < (CW-1)'(eff_w))
                     && (y_s[CW-2:0] < (CW-1)'(eff_h))
                     && (offset_sq <= rr_ff);
   assign probe_addr = AW'(AW'(y_s[CW-2:0]) * ROW_STRIDE + AW'(x_s[CW-2:0]));

   // Clear sweep address
   logic [AW-1:0] clr_ff;

   assign status.clr_last = (clr_ff == LAST_ADDR);

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clr_step) begin
         clr_ff <= clr_ff + AW'(1);
      end
   end

   // Grid memory: one write port, one registered read port
   logic [CELL_BITS-1:0] mem [DEPTH];
   logic [CELL_BITS-1:0] rd_data_ff;
   logic                 mem_we;
   logic [AW-1:0]        mem_waddr;
   logic [CELL_BITS-1:0] mem_wdata;
   logic [AW-1:0]        mem_raddr;

   assign mem_we    = cmd.clr_step || (cmd.load && (req_data.cmd == CMD_WRITE) && req_inside);
   assign mem_waddr = cmd.clr_step ? clr_ff : req_addr;
   assign mem_wdata = cmd.clr_step ? '0 : CELL_BITS'(req_data.value);
   assign mem_raddr = cmd.center ? center_addr_ff : probe_addr;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[mem_raddr];
   end

   // Track which read data returns this cycle
   logic center_pend_ff;
   logic probe_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_pend_ff <= 1'b0;
         probe_ff       <= 1'b0;
      end else begin
         center_pend_ff <= cmd.center;
         probe_ff       <= cmd.scan_step && probe_ok;
      end
   end

   // Collect center value and any occupied neighbor
   logic [CELL_BITS-1:0] center_ff;
   logic                 hit_ff;

   always_ff @(posedge clock) begin
      if (center_pend_ff) begin
         center_ff <= rd_data_ff;
      end
      if (cmd.center) begin
         hit_ff <= 1'b0;
      end else if (probe_ff && (rd_data_ff == CELL_BITS'(1))) begin
         hit_ff <= 1'b1;
      end
   end

   // Result register
   rsp_type rsp_ff;

   always_ff @(posedge clock) begin
      if (cmd.load && status.quick) begin
         if (req_data.cmd == CMD_WRITE) begin
            rsp_ff.cell_value <= '0;
            rsp_ff.status     <= req_inside ? STATUS_OK : STATUS_RANGE;
         end else begin
            rsp_ff.cell_value <= VALUE_BITS'(1);
            rsp_ff.status     <= STATUS_RANGE;
         end
      end else if (cmd.finish) begin
         rsp_ff.cell_value <= hit_ff ? VALUE_BITS'(1) : VALUE_BITS'(center_ff);
         rsp_ff.status     <= STATUS_OK;
      end
   end

   assign rsp_data = rsp_ff;

endmodule
